@@ src/mcg_pkg.sv @@
// Shared types, constants and calendar tables for the month grid block.
package mcg_pkg;

  localparam int unsigned MCG_QDEPTH = 2;

  localparam logic [13:0] YEAR_MIN    = 14'd1;
  localparam logic [13:0] YEAR_MAX    = 14'd9999;
  localparam logic [13:0] RESET_YEAR  = 14'd2026;
  localparam logic [3:0]  RESET_MONTH = 4'd1;
  localparam logic [3:0]  MONTH_MAX   = 4'd12;

  typedef enum logic [1:0] {
    KIND_RENDER = 2'd0,
    KIND_NEXT   = 2'd1,
    KIND_PREV   = 2'd2,
    KIND_TODAY  = 2'd3
  } kind_t;

  typedef enum logic {
    REG_FB_YEAR  = 1'b0,
    REG_FB_MONTH = 1'b1
  } reg_idx_t;

  // One queued render job: the month to show plus what is needed for the today mark.
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic        tmatch;
    logic [4:0]  tday;
  } job_t;

  // Sakamoto month offsets; m is 1..12.
  function automatic logic [2:0] month_shift(input logic [3:0] m);
    logic [2:0] s;
    case (m)
      4'd1:    s = 3'd0;
      4'd2:    s = 3'd3;
      4'd3:    s = 3'd2;
      4'd4:    s = 3'd5;
      4'd5:    s = 3'd0;
      4'd6:    s = 3'd3;
      4'd7:    s = 3'd5;
      4'd8:    s = 3'd1;
      4'd9:    s = 3'd4;
      4'd10:   s = 3'd6;
      4'd11:   s = 3'd2;
      4'd12:   s = 3'd4;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] n;
    case (m)
      4'd2:                   n = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

@@ src/mcg_front.sv @@
// Front end: config registers, event decode and the view year/month state.
module mcg_front import mcg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  input  logic        in_valid,
  input  logic [1:0]  in_kind,
  input  logic        in_today_valid,
  input  logic [13:0] in_today_year,
  input  logic [3:0]  in_today_month,
  input  logic [4:0]  in_today_day,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job
);

  logic [13:0] fb_year_r;
  logic [3:0]  fb_month_r;
  logic [13:0] view_year_r, view_year_nxt;
  logic [3:0]  view_month_r, view_month_nxt;
  logic [13:0] fb_year_c;
  logic [3:0]  fb_month_c;
  logic        clock_ok;
  logic        cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (reg_idx_t'(paddr[2]) == REG_FB_MONTH) ? {28'd0, fb_month_r}
                                                         : {18'd0, fb_year_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_year_r  <= RESET_YEAR;
      fb_month_r <= RESET_MONTH;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_FB_YEAR:  fb_year_r  <= pwdata[13:0];
        REG_FB_MONTH: fb_month_r <= pwdata[3:0];
      endcase
    end
  end

  always_comb begin
    fb_year_c = fb_year_r;
    if (fb_year_r < YEAR_MIN) fb_year_c = YEAR_MIN;
    else if (fb_year_r > YEAR_MAX) fb_year_c = YEAR_MAX;
    fb_month_c = fb_month_r;
    if (fb_month_r == 4'd0) fb_month_c = 4'd1;
    else if (fb_month_r > MONTH_MAX) fb_month_c = MONTH_MAX;
  end

  assign clock_ok = in_today_valid && (in_today_year >= YEAR_MIN) &&
                    (in_today_year <= YEAR_MAX) && (in_today_month != 4'd0) &&
                    (in_today_month <= MONTH_MAX);

  always_comb begin
    view_year_nxt  = view_year_r;
    view_month_nxt = view_month_r;
    unique case (kind_t'(in_kind))
      KIND_RENDER: ;
      KIND_NEXT: begin
        if (view_month_r < MONTH_MAX) begin
          view_month_nxt = view_month_r + 4'd1;
        end else if (view_year_r < YEAR_MAX) begin
          view_month_nxt = 4'd1;
          view_year_nxt  = view_year_r + 14'd1;
        end
      end
      KIND_PREV: begin
        if (view_month_r > 4'd1) begin
          view_month_nxt = view_month_r - 4'd1;
        end else if (view_year_r > YEAR_MIN) begin
          view_month_nxt = MONTH_MAX;
          view_year_nxt  = view_year_r - 14'd1;
        end
      end
      KIND_TODAY: begin
        if (clock_ok) begin
          view_year_nxt  = in_today_year;
          view_month_nxt = in_today_month;
        end else begin
          view_year_nxt  = fb_year_c;
          view_month_nxt = fb_month_c;
        end
      end
    endcase
  end

  assign q_push        = in_valid && !q_full;
  assign q_job.year    = view_year_nxt;
  assign q_job.month   = view_month_nxt;
  assign q_job.tmatch  = in_today_valid && (in_today_year == view_year_nxt) &&
                         (in_today_month == view_month_nxt);
  assign q_job.tday    = in_today_day;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_year_r  <= RESET_YEAR;
      view_month_r <= RESET_MONTH;
    end else if (q_push) begin
      view_year_r  <= view_year_nxt;
      view_month_r <= view_month_nxt;
    end
  end

endmodule

@@ src/mcg_fifo.sv @@
// Small job queue between the event front end and the grid generator.
module mcg_fifo import mcg_pkg::*; #(
  parameter int unsigned DEPTH = MCG_QDEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic full,
  output logic empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      if (push && !pop)      count_r <= count_r + CW'(1);
      else if (pop && !push) count_r <= count_r - CW'(1);
    end
  end

endmodule

@@ src/mcg_back.sv @@
// Back end: first weekday and month length, then one day cell per beat.
module mcg_back import mcg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  job_t        q_job,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_day,
  output logic [2:0]  out_column,
  output logic [2:0]  out_row,
  output logic        out_is_today,
  output logic [13:0] out_shown_year,
  output logic [3:0]  out_shown_month,
  output logic        out_last
);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_SUM, S_MOD, S_EMIT} state_t;

  state_t      state_r;
  job_t        job_r;
  logic [13:0] yy_r;
  logic [6:0]  q100_r;
  logic [14:0] sum_r;
  logic [4:0]  len_r;
  logic [4:0]  day_r;
  logic [2:0]  col_r;
  logic [2:0]  row_r;
  logic        out_valid_r;
  logic [4:0]  out_day_r;
  logic [2:0]  out_col_r, out_row_r;
  logic        out_today_r, out_last_r;
  logic [13:0] out_year_r;
  logic [3:0]  out_month_r;

  logic [26:0] prod100;
  logic [13:0] rem100;
  logic        early;
  logic        cent;
  logic [7:0]  cent_q;
  logic        leap;
  logic [14:0] sum_c;
  logic [31:0] prod7;
  logic [14:0] q7;
  logic [14:0] first_c;
  logic        out_free;

  // yy / 100 via reciprocal, exact for 14-bit yy
  assign prod100 = 27'(yy_r) * 27'd5243;

  // In January/February yy is year-1, so the year is a century when yy % 100 is 99.
  assign early  = (job_r.month < 4'd3);
  assign rem100 = yy_r - 14'(q100_r) * 14'd100;
  assign cent   = early ? (rem100 == 14'd99) : (rem100 == 14'd0);
  assign cent_q = early ? 8'(q100_r) + 8'd1 : 8'(q100_r);
  assign leap   = ((job_r.year[1:0] == 2'd0) && !cent) || (cent && (cent_q[1:0] == 2'd0));
  assign sum_c  = 15'(yy_r) + 15'(yy_r >> 2) - 15'(q100_r) + 15'(q100_r >> 2) +
                  15'(month_shift(job_r.month)) + 15'd1;

  // sum % 7 via reciprocal, exact below 43690
  assign prod7   = 32'(sum_r) * 32'd37450;
  assign q7      = 15'(prod7 >> 18);
  assign first_c = sum_r - q7 * 15'd7;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // while emitting, the output register is reloaded whenever it frees up
      if (out_valid_r && !out_stall && (state_r != S_EMIT)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            job_r   <= q_job;
            yy_r    <= (q_job.month < 4'd3) ? q_job.year - 14'd1 : q_job.year;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          q100_r  <= 7'(prod100 >> 19);
          state_r <= S_SUM;
        end
        S_SUM: begin
          sum_r   <= sum_c;
          len_r   <= ((job_r.month == 4'd2) && leap) ? 5'd29 : month_len(job_r.month);
          state_r <= S_MOD;
        end
        S_MOD: begin
          col_r   <= first_c[2:0];
          row_r   <= 3'd0;
          day_r   <= 5'd1;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_day_r   <= day_r;
            out_col_r   <= col_r;
            out_row_r   <= row_r;
            out_today_r <= job_r.tmatch && (job_r.tday == day_r);
            out_year_r  <= job_r.year;
            out_month_r <= job_r.month;
            out_last_r  <= (day_r == len_r);
            day_r       <= day_r + 5'd1;
            if (col_r == 3'd6) begin
              col_r <= 3'd0;
              row_r <= row_r + 3'd1;
            end else begin
              col_r <= col_r + 3'd1;
            end
            if (day_r == len_r) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_day         = out_day_r;
  assign out_column      = out_col_r;
  assign out_row         = out_row_r;
  assign out_is_today    = out_today_r;
  assign out_shown_year  = out_year_r;
  assign out_shown_month = out_month_r;
  assign out_last        = out_last_r;

endmodule

@@ src/month_calendar_grid_top.sv @@
// Top level of the month calendar grid generator.
//
//  channel | direction | handshake          | beat
//  in_*    | input     | in_valid/in_stall   | one event (render/next/prev/today)
//  out_*   | output    | out_valid/out_stall | one day cell of the shown month
//  cfg     | input     | APB psel/penable    | fallback year and month registers
//
// An event is taken into a job queue (depth QDEPTH); the grid unit then does the
// weekday and month length math in its divide, sum and mod states and emits 28 to 31
// cells, one per cycle while the output is not stalled.
// Synchronous active-low reset: view is January 2026, fallback is January 2026.
// in_stall rises only when the job queue is full; out_stall freezes the output register.
module month_calendar_grid_top import mcg_pkg::*; #(
  parameter int unsigned QDEPTH = MCG_QDEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic        in_today_valid,
  input  logic [13:0] in_today_year,
  input  logic [3:0]  in_today_month,
  input  logic [4:0]  in_today_day,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_day,
  output logic [2:0]  out_column,
  output logic [2:0]  out_row,
  output logic        out_is_today,
  output logic [13:0] out_shown_year,
  output logic [3:0]  out_shown_month,
  output logic        out_last
);

  logic q_full, q_empty, q_push, q_pop;
  job_t push_job, pop_job;

  assign pready   = 1'b1;
  assign in_stall = q_full;

  mcg_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .in_valid       (in_valid),
    .in_kind        (in_kind),
    .in_today_valid (in_today_valid),
    .in_today_year  (in_today_year),
    .in_today_month (in_today_month),
    .in_today_day   (in_today_day),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  mcg_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  mcg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_job           (pop_job),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_day         (out_day),
    .out_column      (out_column),
    .out_row         (out_row),
    .out_is_today    (out_is_today),
    .out_shown_year  (out_shown_year),
    .out_shown_month (out_shown_month),
    .out_last        (out_last)
  );

endmodule
